>>> hw/rtl/gmbs_pkg.sv
`timescale 1ns / 1ps

package gmbs_pkg;

   // Operation codes on the request channel
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Cell codes held in the grid
   localparam logic [2:0] CELL_PASS  = 3'd0;
   localparam logic [2:0] CELL_WALL  = 3'd1;
   localparam logic [2:0] CELL_START = 3'd2;
   localparam logic [2:0] CELL_END   = 3'd3;
   localparam logic [2:0] CELL_PATH  = 3'd4;

   // Response status codes
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_FOUND   = 2'd1;
   localparam logic [1:0] STAT_NO_PATH = 2'd2;
   localparam logic [1:0] STAT_MISSING = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_ROWS_USED = 2'd0;
   localparam logic [1:0] CSR_COLS_USED = 2'd1;

   // Search direction that means all four neighbours are done
   localparam logic [2:0] DIR_DONE = 3'd4;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_STEP,
      ST_POP,
      ST_CHECK,
      ST_MARK_TOP,
      ST_MARK
   } state_type;

endpackage

>>> hw/rtl/grid_maze_backtrack_solver_core.sv
`timescale 1ns / 1ps

// Channel | Direction | Ports                                          | Handshake
// req     | in        | req_operation, req_row, req_col, req_cell_kind | req_valid / req_ready
// rsp     | out       | rsp_status, rsp_cell_code                      | rsp_valid / rsp_ready
// csr     | in        | csr_index, csr_wdata                           | csr_we, no wait
//
// A cell write is answered straight from idle; a cell read answers from the read state,
// after the registered grid memory read. A solve first clears the visited map, then probes
// neighbours in the step and check states, backtracks through the pop state and, once the
// end is found, marks each path cell. After reset a clearing pass sets every cell to pass;
// no request is taken until it ends. One request is in flight at a time; a response
// waiting on rsp_ready holds req_ready low until its transfer.
module grid_maze_backtrack_solver_core #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [4:0] req_row,
   input  logic [4:0] req_col,
   input  logic [1:0] req_cell_kind,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_cell_code,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata
);
   import gmbs_pkg::*;

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = AW + 3;

   // Memories
   logic [2:0]    grid_mem  [DEPTH];
   logic          vis_mem   [DEPTH];
   logic [SW-1:0] stk_mem   [DEPTH];

   state_type state_ff, state_in;

   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW:0]   depth_ff, depth_in;
   logic [AW-1:0] top_pos_ff, top_pos_in;
   logic [2:0]    top_dir_ff, top_dir_in;
   logic [AW-1:0] nb_pos_ff, nb_pos_in;
   logic [AW-1:0] start_pos_ff, start_pos_in;
   logic [AW-1:0] end_pos_ff, end_pos_in;
   logic          start_seen_ff, start_seen_in;
   logic          end_seen_ff, end_seen_in;
   logic [4:0]    rows_used_ff, rows_used_in;
   logic [4:0]    cols_used_ff, cols_used_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [2:0]    rsp_code_ff, rsp_code_in;

   logic [2:0]    grid_rd_ff;
   logic          vis_rd_ff;
   logic [SW-1:0] stk_rd_ff;

   logic          grid_we, grid_re, vis_we, stk_we, stk_re;
   logic [AW-1:0] grid_wa, grid_ra, vis_wa, vis_ra, stk_wa, stk_ra;
   logic [2:0]    grid_wd;
   logic          vis_wd;
   logic [SW-1:0] stk_wd;

   logic          accept, cell_ok, cnt_last, both_seen, blocked, nb_ok, mark_last;
   logic [AW-1:0] req_addr, nb_addr;
   logic [6:0]    nr, nc, tr7, tc7, nb_row7, nb_col7, rows7, cols7;

   // Request decode
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign cell_ok   = (req_row != 5'd0) && (req_col != 5'd0)
                      && ({2'b00, req_row} <= 7'(MAX_ROWS))
                      && ({2'b00, req_col} <= 7'(MAX_COLS));
   assign req_addr  = {RW'({2'b00, req_row} - 7'd1), CW'({2'b00, req_col} - 7'd1)};
   assign cnt_last  = (cnt_ff == {AW{1'b1}});
   assign both_seen = start_seen_ff && end_seen_ff;
   assign blocked   = (grid_rd_ff == CELL_WALL) || vis_rd_ff;
   assign mark_last = ((AW + 1)'(cnt_ff) + (AW + 1)'(2)) == depth_ff;

   // Saturated bounds of the used area
   assign rows7 = {2'b00, rows_used_ff};
   assign cols7 = {2'b00, cols_used_ff};
   assign nr    = (rows7 > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows7;
   assign nc    = (cols7 > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols7;

   // Neighbour of the top frame; a step off row or column zero wraps out of range
   assign tr7 = 7'(top_pos_ff[AW-1:CW]);
   assign tc7 = 7'(top_pos_ff[CW-1:0]);
   always_comb begin
      nb_row7 = tr7;
      nb_col7 = tc7;
      case (top_dir_ff)
         3'd0:    nb_row7 = tr7 - 7'd1;
         3'd1:    nb_col7 = tc7 + 7'd1;
         3'd2:    nb_row7 = tr7 + 7'd1;
         3'd3:    nb_col7 = tc7 - 7'd1;
         default: nb_row7 = tr7;
      endcase
   end
   assign nb_ok   = (nb_row7 < nr) && (nb_col7 < nc);
   assign nb_addr = {nb_row7[RW-1:0], nb_col7[CW-1:0]};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_READ) state_in = ST_READ;
               else if (req_operation == OP_SOLVE && both_seen) state_in = ST_CLEAR;
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_CLEAR: begin
            if (cnt_last) state_in = (start_pos_ff == end_pos_ff) ? ST_IDLE : ST_STEP;
         end
         ST_STEP: begin
            if (top_dir_ff == DIR_DONE) begin
               state_in = (depth_ff == (AW + 1)'(1)) ? ST_IDLE : ST_POP;
            end else if (nb_ok) begin
               state_in = ST_CHECK;
            end
         end
         ST_POP: state_in = ST_STEP;
         ST_CHECK: begin
            if (!blocked && nb_pos_ff == end_pos_ff) state_in = ST_MARK_TOP;
            else state_in = ST_STEP;
         end
         ST_MARK_TOP: begin
            state_in = (depth_ff == (AW + 1)'(1)) ? ST_IDLE : ST_MARK;
         end
         ST_MARK: begin
            if (mark_last) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      cnt_in        = cnt_ff;
      depth_in      = depth_ff;
      top_pos_in    = top_pos_ff;
      top_dir_in    = top_dir_ff;
      nb_pos_in     = nb_pos_ff;
      start_pos_in  = start_pos_ff;
      end_pos_in    = end_pos_ff;
      start_seen_in = start_seen_ff;
      end_seen_in   = end_seen_ff;
      rows_used_in  = rows_used_ff;
      cols_used_in  = cols_used_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_code_in   = rsp_code_ff;
      grid_we = 1'b0;  grid_wa = cnt_ff;   grid_wd = CELL_PASS;
      grid_re = 1'b0;  grid_ra = req_addr;
      vis_we  = 1'b0;  vis_wa  = cnt_ff;   vis_wd  = 1'b0;
      vis_ra  = nb_addr;
      stk_we  = 1'b0;  stk_wa  = AW'(depth_ff - (AW + 1)'(1));
      stk_wd  = {top_pos_ff, top_dir_ff};
      stk_re  = 1'b0;  stk_ra  = AW'(depth_ff - (AW + 1)'(2));

      // Configuration writes
      if (csr_we) begin
         if (csr_index == CSR_ROWS_USED) rows_used_in = csr_wdata;
         if (csr_index == CSR_COLS_USED) cols_used_in = csr_wdata;
      end

      case (state_ff)
         ST_INIT: begin
            grid_we = 1'b1;
            cnt_in  = cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               cnt_in     = '0;
               top_pos_in = start_pos_ff;
               top_dir_in = 3'd0;
               depth_in   = (AW + 1)'(1);
               rd_ok_in   = cell_ok;
               grid_re    = 1'b1;
               case (req_operation)
                  OP_WRITE: begin
                     grid_we       = cell_ok;
                     grid_wa       = req_addr;
                     grid_wd       = {1'b0, req_cell_kind};
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_DONE;
                     rsp_code_in   = CELL_PASS;
                     if (cell_ok && {1'b0, req_cell_kind} == CELL_START) begin
                        start_pos_in  = req_addr;
                        start_seen_in = 1'b1;
                     end
                     if (cell_ok && {1'b0, req_cell_kind} == CELL_END) begin
                        end_pos_in  = req_addr;
                        end_seen_in = 1'b1;
                     end
                  end
                  OP_SOLVE: begin
                     if (!both_seen) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_MISSING;
                        rsp_code_in   = CELL_PASS;
                     end
                  end
                  OP_READ: begin
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_DONE;
                     rsp_code_in   = CELL_PASS;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_DONE;
            rsp_code_in   = rd_ok_ff ? grid_rd_ff : CELL_PASS;
         end
         ST_CLEAR: begin
            // Clear the visited map, leaving the start marked
            vis_we = 1'b1;
            vis_wd = (cnt_ff == start_pos_ff);
            cnt_in = cnt_ff + AW'(1);
            if (cnt_last && start_pos_ff == end_pos_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_FOUND;
               rsp_code_in   = CELL_PASS;
            end
         end
         ST_STEP: begin
            if (top_dir_ff == DIR_DONE) begin
               if (depth_ff == (AW + 1)'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NO_PATH;
                  rsp_code_in   = CELL_PASS;
               end else begin
                  stk_re = 1'b1;
               end
            end else begin
               // Advance direction and probe the neighbour
               top_dir_in = top_dir_ff + 3'd1;
               nb_pos_in  = nb_addr;
               grid_re    = 1'b1;
               grid_ra    = nb_addr;
            end
         end
         ST_POP: begin
            top_pos_in = stk_rd_ff[SW-1:3];
            top_dir_in = stk_rd_ff[2:0];
            depth_in   = depth_ff - (AW + 1)'(1);
         end
         ST_CHECK: begin
            if (!blocked && nb_pos_ff != end_pos_ff) begin
               // Push the current frame and descend
               stk_we     = 1'b1;
               vis_we     = 1'b1;
               vis_wa     = nb_pos_ff;
               vis_wd     = 1'b1;
               top_pos_in = nb_pos_ff;
               top_dir_in = 3'd0;
               depth_in   = depth_ff + (AW + 1)'(1);
            end
         end
         ST_MARK_TOP: begin
            grid_we = 1'b1;
            grid_wa = top_pos_ff;
            grid_wd = CELL_PATH;
            cnt_in  = '0;
            stk_re  = 1'b1;
            stk_ra  = '0;
            if (depth_ff == (AW + 1)'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_FOUND;
               rsp_code_in   = CELL_PASS;
            end
         end
         ST_MARK: begin
            // Mark one stacked cell a cycle, reading the next behind it
            grid_we = 1'b1;
            grid_wa = stk_rd_ff[SW-1:3];
            grid_wd = CELL_PATH;
            cnt_in  = cnt_ff + AW'(1);
            stk_re  = 1'b1;
            stk_ra  = cnt_ff + AW'(1);
            if (mark_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_FOUND;
               rsp_code_in   = CELL_PASS;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         depth_ff      <= '0;
         start_pos_ff  <= '0;
         end_pos_ff    <= '0;
         start_seen_ff <= 1'b0;
         end_seen_ff   <= 1'b0;
         rows_used_ff  <= 5'd16;
         cols_used_ff  <= 5'd16;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         depth_ff      <= depth_in;
         start_pos_ff  <= start_pos_in;
         end_pos_ff    <= end_pos_in;
         start_seen_ff <= start_seen_in;
         end_seen_ff   <= end_seen_in;
         rows_used_ff  <= rows_used_in;
         cols_used_ff  <= cols_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_pos_ff    <= top_pos_in;
      top_dir_ff    <= top_dir_in;
      nb_pos_ff     <= nb_pos_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_code_ff   <= rsp_code_in;
   end

   // Grid memory
   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_wa] <= grid_wd;
      if (grid_re) grid_rd_ff <= grid_mem[grid_ra];
   end

   // Visited map
   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      vis_rd_ff <= vis_mem[vis_ra];
   end

   // Search stack
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (stk_re) stk_rd_ff <= stk_mem[stk_ra];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_cell_code = rsp_code_ff;

   // Checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("request taken outside idle");

   a_depth_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_POP || state_ff == ST_CHECK)
      |-> (depth_ff != '0))
      else $error("search running with empty stack");

   a_write_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_WRITE) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("cell write gave no response");

endmodule
